// File: rtl/core/gda_pkg.sv
package gda_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned ADD_W   = 15;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned YLEN_W  = 9;
  localparam int unsigned R400_W  = 9;

  // Reciprocal of 400 scaled by two to the 23rd, exact for every 14-bit year.
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned RECIP_W     = 15;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_400 = RECIP_W'(20972);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_SUM,
    ST_WALK,
    ST_DONE
  } gda_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic modr;
    logic sum;
    logic step;
    logic out_load;
  } gda_cmd_t;

  typedef struct packed {
    logic walk_done;
  } gda_status_t;

  // Leap rule from the year modulo 400 and its two low bits.
  function automatic logic is_leap(input logic [R400_W-1:0] r400,
                                   input logic [1:0] ylow);
    return (r400 == R400_W'(0)) ||
           ((ylow == 2'b00) && (r400 != R400_W'(100)) &&
            (r400 != R400_W'(200)) && (r400 != R400_W'(300)));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                   len = DAY_W'(30);
      4'd2:                                      len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                   len = DAY_W'(0);
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year; months above
  // December cover the whole year.
  function automatic logic [YLEN_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [YLEN_W-1:0] d;
    case (m)
      4'd2:    d = YLEN_W'(31);
      4'd3:    d = YLEN_W'(59);
      4'd4:    d = YLEN_W'(90);
      4'd5:    d = YLEN_W'(120);
      4'd6:    d = YLEN_W'(151);
      4'd7:    d = YLEN_W'(181);
      4'd8:    d = YLEN_W'(212);
      4'd9:    d = YLEN_W'(243);
      4'd10:   d = YLEN_W'(273);
      4'd11:   d = YLEN_W'(304);
      4'd12:   d = YLEN_W'(334);
      4'd13, 4'd14, 4'd15: d = YLEN_W'(365);
      default: d = YLEN_W'(0);
    endcase
    return d;
  endfunction

endpackage

// File: rtl/core/gda_if.sv
interface gda_in_if;
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DAY_W-1:0]   start_day;
  logic [gda_pkg::MONTH_W-1:0] start_month;
  logic [gda_pkg::YEAR_W-1:0]  start_year;
  logic [gda_pkg::ADD_W-1:0]   days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink (input valid, start_day, start_month, start_year, days_to_add,
                output ready);
endinterface

interface gda_out_if;
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DAY_W-1:0]   result_day;
  logic [gda_pkg::MONTH_W-1:0] result_month;
  logic [gda_pkg::YEAR_W-1:0]  result_year;

  modport source (output valid, result_day, result_month, result_year,
                  input ready);
  modport sink (input valid, result_day, result_month, result_year,
                output ready);
endinterface

// File: rtl/core/gda_ctrl.sv
module gda_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gda_pkg::gda_cmd_t    cmd,
  input  gda_pkg::gda_status_t status
);
  import gda_pkg::*;

  gda_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.modr  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/gda_dp.sv
module gda_dp (
  input  logic                          clk,
  input  logic [gda_pkg::DAY_W-1:0]     start_day,
  input  logic [gda_pkg::MONTH_W-1:0]   start_month,
  input  logic [gda_pkg::YEAR_W-1:0]    start_year,
  input  logic [gda_pkg::ADD_W-1:0]     days_to_add,
  input  gda_pkg::gda_cmd_t             cmd,
  output gda_pkg::gda_status_t          status,
  output logic [gda_pkg::DAY_W-1:0]     result_day,
  output logic [gda_pkg::MONTH_W-1:0]   result_month,
  output logic [gda_pkg::YEAR_W-1:0]    result_year
);
  import gda_pkg::*;

  logic [DAY_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic [ADD_W-1:0]   add_r;
  logic [PROD_W-1:0]  prod_r;
  logic [R400_W-1:0]  r400_r;
  logic [TOTAL_W-1:0] total_r;
  logic [DAY_W-1:0]   res_day_r;
  logic [MONTH_W-1:0] res_month_r;
  logic [YEAR_W-1:0]  res_year_r;

  logic [QUOT_W-1:0]  quot;
  logic [YEAR_W-1:0]  quot_x400;
  logic               leap;
  logic [YLEN_W-1:0]  year_len;
  logic [DAY_W-1:0]   mon_len;
  logic               skip_year;
  logic               skip_month;
  logic [YEAR_W-1:0]  year_inc;
  logic [R400_W-1:0]  r400_inc;
  logic [YLEN_W-1:0]  days_prior;

  assign quot      = prod_r[PROD_W-1:RECIP_SHIFT];
  assign quot_x400 = {{(YEAR_W-QUOT_W){1'b0}}, quot} * YEAR_W'(400);

  assign leap       = is_leap(r400_r, year_r[1:0]);
  assign year_len   = leap ? YLEN_W'(366) : YLEN_W'(365);
  assign mon_len    = month_len(month_r, leap);
  assign days_prior = days_before(month_r) +
                      ((leap && (month_r >= MONTH_MAR)) ? YLEN_W'(1) : YLEN_W'(0));

  // A whole year is skipped from January when the remainder outlasts it.
  assign skip_year  = (month_r == MONTH_JAN) &&
                      (total_r > {{(TOTAL_W-YLEN_W){1'b0}}, year_len});
  assign skip_month = total_r > {{(TOTAL_W-DAY_W){1'b0}}, mon_len};
  assign status.walk_done = !skip_year && !skip_month;

  // The year wraps at the counter width, so its residue restarts at zero.
  assign year_inc = year_r + YEAR_W'(1);
  always_comb begin
    if (year_r == {YEAR_W{1'b1}} || r400_r == R400_W'(399)) begin
      r400_inc = '0;
    end else begin
      r400_inc = r400_r + R400_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r   <= start_day;
      month_r <= start_month;
      year_r  <= start_year;
      add_r   <= days_to_add;
    end
    if (cmd.mul) begin
      prod_r <= {{RECIP_W{1'b0}}, year_r} * {{YEAR_W{1'b0}}, RECIP_400};
    end
    if (cmd.modr) begin
      r400_r <= R400_W'(year_r - quot_x400);
    end
    if (cmd.sum) begin
      total_r <= {{(TOTAL_W-YLEN_W){1'b0}}, days_prior} +
                 {{(TOTAL_W-DAY_W){1'b0}}, day_r} +
                 {{(TOTAL_W-ADD_W){1'b0}}, add_r};
      month_r <= MONTH_JAN;
    end
    if (cmd.step) begin
      if (skip_year) begin
        total_r <= total_r - {{(TOTAL_W-YLEN_W){1'b0}}, year_len};
        year_r  <= year_inc;
        r400_r  <= r400_inc;
      end else begin
        total_r <= total_r - {{(TOTAL_W-DAY_W){1'b0}}, mon_len};
        if (month_r == MONTH_DEC) begin
          month_r <= MONTH_JAN;
          year_r  <= year_inc;
          r400_r  <= r400_inc;
        end else begin
          month_r <= month_r + MONTH_W'(1);
        end
      end
    end
    if (cmd.out_load) begin
      res_day_r   <= total_r[DAY_W-1:0];
      res_month_r <= month_r;
      res_year_r  <= year_r;
    end
  end

  assign result_day   = res_day_r;
  assign result_month = res_month_r;
  assign result_year  = res_year_r;

endmodule

// File: rtl/core/gregorian_date_add_days_top.sv
// Channel   Dir  Payload                                          Transfer
// in_ch     in   start_day, start_month, start_year, days_to_add  valid && ready
// out_ch    out  result_day, result_month, result_year            valid && ready
//
// One item is in work at a time. After the input transfer, the multiply, modulo
// and sum states form the year residue and the day count; the walk then skips
// one whole year or steps one month per cycle (at most 90 and 11) until done,
// and the done state loads the result register once the output is free or taken.
// Reset is synchronous and active low; it clears the controller and out valid.
// A waiting result stalls only that load; the next input is taken after it.
module gregorian_date_add_days_top (
  input logic       clk,
  input logic       rst_n,
  gda_in_if.sink    in_ch,
  gda_out_if.source out_ch
);
  import gda_pkg::*;

  gda_cmd_t    cmd;
  gda_status_t status;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  gda_dp u_dp (
    .clk          (clk),
    .start_day    (in_ch.start_day),
    .start_month  (in_ch.start_month),
    .start_year   (in_ch.start_year),
    .days_to_add  (in_ch.days_to_add),
    .cmd          (cmd),
    .status       (status),
    .result_day   (out_ch.result_day),
    .result_month (out_ch.result_month),
    .result_year  (out_ch.result_year)
  );

endmodule

// File: tb/sv/tb_gregorian_date_add_days_top.sv
`timescale 1ns / 1ps

module tb_gregorian_date_add_days_top;
  import gda_pkg::*;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [ADD_W-1:0]   add;
  } date_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_out_t;

  typedef struct {
    date_in_t  din;
    bit        typed;
    date_out_t dout;
  } stim_row_t;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 150;
  localparam int unsigned ITEMS_PER_PHASE = 325;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned YEAR_MASK       = (1 << YEAR_W) - 1;

  logic clk;
  logic rst_n;

  gda_in_if  in_ch ();
  gda_out_if out_ch ();

  gregorian_date_add_days_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  date_out_t   expected_dates[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit year_is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    if (m < 1 || m > 12) return 0;
    case (m)
      2:          return year_is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic date_out_t add_days_to_date(input date_in_t d);
    int unsigned total;
    int unsigned m;
    int unsigned y;
    date_out_t   r;
    y = d.year;
    total = 0;
    for (m = 1; m < d.month; m++) total += month_days(y, m);
    total += d.day + d.add;
    m = 1;
    while (total > month_days(y, m)) begin
      total -= month_days(y, m);
      m++;
      if (m > 12) begin
        m = 1;
        y = (y + 1) & YEAR_MASK;
      end
    end
    r.day   = DAY_W'(total);
    r.month = MONTH_W'(m);
    r.year  = YEAR_W'(y);
    return r;
  endfunction

  function automatic void add_row(input int unsigned dd, input int unsigned mm,
                                  input int unsigned yy, input int unsigned aa,
                                  input bit typed = 1'b0, input int unsigned rd = 0,
                                  input int unsigned rm = 0, input int unsigned ry = 0);
    stim_row_t row;
    row.din.day    = DAY_W'(dd);
    row.din.month  = MONTH_W'(mm);
    row.din.year   = YEAR_W'(yy);
    row.din.add    = ADD_W'(aa);
    row.typed      = typed;
    row.dout.day   = DAY_W'(rd);
    row.dout.month = MONTH_W'(rm);
    row.dout.year  = YEAR_W'(ry);
    directed_rows.push_back(row);
  endfunction

  task automatic send_date(input date_in_t d, input date_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.start_day   <= d.day;
    in_ch.start_month <= d.month;
    in_ch.start_year  <= d.year;
    in_ch.days_to_add <= d.add;
    do @(posedge clk); while (!in_ch.ready);
    expected_dates.push_back(want);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    date_out_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dates.size() == 0) begin
          $error("result transfer with no date expected");
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          if (out_ch.result_day !== want.day) begin
            $error("result_day: expected %0d, actual %0d", want.day, out_ch.result_day);
            mismatches++;
          end
          if (out_ch.result_month !== want.month) begin
            $error("result_month: expected %0d, actual %0d", want.month,
                   out_ch.result_month);
            mismatches++;
          end
          if (out_ch.result_year !== want.year) begin
            $error("result_year: expected %0d, actual %0d", want.year, out_ch.result_year);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    date_in_t    d;
    date_out_t   want;
    int unsigned pick;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.start_day   <= '0;
    in_ch.start_month <= '0;
    in_ch.start_year  <= '0;
    in_ch.days_to_add <= '0;

    add_row(0, 0, 2023, 0, 1'b1, 0, 1, 2023);
    add_row(0, 0, 0, 0, 1'b1, 0, 1, 0);
    add_row(1, 1, 0, 0, 1'b1, 1, 1, 0);
    add_row(31, 12, 9999, 0, 1'b1, 31, 12, 9999);
    add_row(31, 12, 9999, 1, 1'b1, 1, 1, 10000);
    add_row(31, 12, 16383, 1, 1'b1, 1, 1, 0);
    add_row(31, 15, 16383, 32767);
    add_row(31, 1, 9999, 32767);
    add_row(1, 1, 2024, 32767);
    add_row(28, 2, 2000, 1);
    add_row(28, 2, 1900, 1);
    add_row(28, 2, 2024, 1);
    add_row(28, 2, 2023, 1);
    add_row(29, 2, 0, 0);
    add_row(31, 2, 2023, 0);
    add_row(31, 4, 2023, 0);
    add_row(5, 0, 2023, 10);
    add_row(1, 13, 2023, 0);
    add_row(10, 14, 1999, 100);
    add_row(15, 6, 2020, 365);
    add_row(1, 3, 2100, 0);
    add_row(31, 12, 16380, 366);
    add_row(20, 10, 16370, 5000);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].dout
                                    : add_days_to_date(directed_rows[i].din);
      send_date(directed_rows[i].din, want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        case ($urandom_range(3))
          0:       d.add = ADD_W'($urandom_range(40));
          1:       d.add = ADD_W'($urandom_range(400));
          2:       d.add = ADD_W'($urandom_range(4000));
          default: d.add = ADD_W'($urandom_range(32767));
        endcase
        pick = $urandom_range(99);
        if (pick < 90) begin
          if (pick < 80) d.year = YEAR_W'($urandom_range(9999));
          else d.year = YEAR_W'($urandom_range(16383, 16290));
          d.month = MONTH_W'($urandom_range(12, 1));
          d.day   = DAY_W'($urandom_range(month_days(d.year, d.month), 1));
        end else begin
          d.day   = DAY_W'($urandom);
          d.month = MONTH_W'($urandom);
          d.year  = YEAR_W'($urandom);
        end
        send_date(d, add_days_to_date(d));
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
